// ===== rtl/pidd_pkg.sv =====
// shared types, widths and constants of the pid controller with integral deadband
package pidd_pkg;

  localparam int SampleBits = 12;
  localparam int SetpointW  = 12;
  localparam int DeadbandW  = 12;
  localparam int ErrLinW    = ((SampleBits > SetpointW) ? SampleBits : SetpointW) + 1;
  localparam int MagLinW    = ErrLinW - 1;
  localparam int GainW      = 48;
  localparam int IntW       = 48;
  localparam int ErrW       = 32;
  localparam int DerivW     = ErrW + 1;
  localparam int DigitW     = 16;
  localparam int NumDigits  = GainW / DigitW;
  localparam int DigitIdxW  = $clog2(NumDigits);
  localparam int NumTerms   = 3;
  localparam int ProdW      = GainW + DigitW;
  localparam int AccW       = 2 * GainW + 3;
  localparam int FracBits   = 32;
  localparam int DriveW     = 15;
  localparam int DriveLimit = 12000;
  localparam int CfgIndexW  = 3;
  localparam int CfgDataW   = GainW;
  localparam int InDataW    = ((SampleBits + 7) / 8) * 8;
  localparam int OutDataW   = ((DriveW + ErrW + 7) / 8) * 8;

  typedef enum logic [CfgIndexW-1:0] {
    CfgSetpoint = 3'd0,
    CfgGainP    = 3'd1,
    CfgGainI    = 3'd2,
    CfgGainD    = 3'd3,
    CfgDeadband = 3'd4,
    CfgCube     = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    TermInt,
    TermDeriv,
    TermProp
  } term_e;

  typedef enum logic [1:0] {
    MulNone,
    MulSquare,
    MulCube,
    MulTerm
  } mul_op_e;

  typedef enum logic [3:0] {
    StIdle,
    StSquare,
    StCube,
    StError,
    StInteg,
    StMag,
    StMul,
    StAcc,
    StDone
  } state_e;

  typedef struct packed {
    logic [SetpointW-1:0] setpoint;
    logic [GainW-1:0]     gain_p;
    logic [GainW-1:0]     gain_i;
    logic [GainW-1:0]     gain_d;
    logic [DeadbandW-1:0] deadband;
    logic                 cube_error;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    setpoint:   '0,
    gain_p:     '0,
    gain_i:     '0,
    gain_d:     '0,
    deadband:   DeadbandW'(20),
    cube_error: 1'b0
  };

  typedef struct packed {
    logic                 load;
    mul_op_e              mul_op;
    logic                 err_load;
    logic                 int_update;
    logic                 mag_load;
    logic                 acc_add;
    logic                 out_load;
    term_e                term;
    logic [DigitIdxW-1:0] digit;
  } dp_cmd_t;

  typedef struct packed {
    logic cube_en;
  } dp_sts_t;

endpackage

// ===== rtl/pidd_ctrl.sv =====
// sequencer of the pid controller: handshakes and datapath commands
module pidd_ctrl import pidd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    s_valid_i,
  output logic    s_ready_o,
  output logic    m_valid_o,
  input  logic    m_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e               state_q, state_d;
  term_e                term_q, term_d;
  logic [DigitIdxW-1:0] digit_q, digit_d;
  logic                 out_valid_q, out_valid_d;
  logic                 last_digit, last_term;

  assign last_digit = (digit_q == DigitIdxW'(NumDigits - 1));
  assign last_term  = (term_q == TermProp);
  assign m_valid_o  = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      term_q      <= TermInt;
      digit_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      term_q      <= term_d;
      digit_q     <= digit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    term_d      = term_q;
    digit_d     = digit_q;
    out_valid_d = out_valid_q && !m_ready_i;
    s_ready_o   = 1'b0;
    cmd_o       = '0;
    cmd_o.term  = term_q;
    cmd_o.digit = digit_q;
    unique case (state_q)
      StIdle: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.cube_en ? StSquare : StError;
        end
      end
      StSquare: begin
        cmd_o.mul_op = MulSquare;
        state_d      = StCube;
      end
      StCube: begin
        cmd_o.mul_op = MulCube;
        state_d      = StError;
      end
      StError: begin
        cmd_o.err_load = 1'b1;
        state_d        = StInteg;
      end
      StInteg: begin
        cmd_o.int_update = 1'b1;
        state_d          = StMag;
      end
      StMag: begin
        cmd_o.mag_load = 1'b1;
        term_d         = TermInt;
        digit_d        = '0;
        state_d        = StMul;
      end
      StMul: begin
        cmd_o.mul_op = MulTerm;
        state_d      = StAcc;
      end
      StAcc: begin
        cmd_o.acc_add = 1'b1;
        state_d       = StMul;
        if (last_digit) begin
          digit_d = '0;
          if (last_term) begin
            term_d  = TermInt;
            state_d = StDone;
          end else begin
            term_d = term_e'(term_q + 2'd1);
          end
        end else begin
          digit_d = digit_q + DigitIdxW'(1);
        end
      end
      StDone: begin
        if (!out_valid_q || m_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

`ifndef SYNTHESIS
  // the term and digit counters have wrapped by the time a result is written
  a_counters_wrapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (term_q == TermInt) && (digit_q == '0))
    else $error("mac counters not wrapped at result write");

  // one beat at a time: no second beat right after an accepted one
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_valid_i && s_ready_o) |=> !s_ready_o)
    else $error("input taken while a beat is in flight");

  // output valid only rises out of the done state
  a_valid_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StDone))
    else $error("result valid raised outside done state");

  // after the last accumulate the result is written or waits behind a full slot
  a_done_follows_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StAcc) && last_digit && last_term) |=> (cmd_o.out_load || out_valid_q))
    else $error("finished mac neither written nor waiting");
`endif

endmodule

// ===== rtl/pidd_dp.sv =====
// datapath of the pid controller: error, integral, derivative and shared multiply-accumulate
module pidd_dp import pidd_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cfg_t                     cfg_i,
  input  dp_cmd_t                  cmd_i,
  output dp_sts_t                  sts_o,
  input  logic [SampleBits-1:0]    sample_i,
  input  logic                     clear_i,
  output logic signed [DriveW-1:0] drive_o,
  output logic signed [ErrW-1:0]   error_o
);

  localparam logic signed [ErrW-1:0] ErrMax = {1'b0, {(ErrW-1){1'b1}}};
  localparam logic signed [ErrW-1:0] ErrMin = {1'b1, {(ErrW-1){1'b0}}};
  localparam logic signed [IntW-1:0] IntMax = {1'b0, {(IntW-1){1'b1}}};
  localparam logic signed [IntW-1:0] IntMin = {1'b1, {(IntW-1){1'b0}}};
  localparam int WholeW = AccW - FracBits;
  localparam logic signed [WholeW-1:0] LimPos = WholeW'(DriveLimit);
  localparam logic signed [WholeW-1:0] LimNeg = -LimPos;
  localparam logic signed [DriveW-1:0] DrivePos = DriveW'(DriveLimit);
  localparam logic signed [DriveW-1:0] DriveNeg = -DrivePos;

  logic signed [ErrLinW-1:0] err_lin_q, err_lin_d;
  logic                      clr_q;
  logic [MagLinW-1:0]        mag_lin;

  logic [GainW-1:0]          mul_a, gain_sel, mag_sel;
  logic [DigitW-1:0]         mul_b;
  logic [ProdW-1:0]          prod_q, prod_d;

  logic signed [ErrW-1:0]    err_q, err_d, cube_sat;
  logic [ErrW-1:0]           err_abs;
  logic signed [IntW-1:0]    int_q, int_d, int_base, int_sat;
  logic signed [IntW:0]      int_sum;
  logic [IntW-1:0]           int_abs;
  logic signed [ErrW-1:0]    prev_q;
  logic signed [DerivW-1:0]  deriv_q, deriv_d;
  logic [DerivW-1:0]         deriv_abs;

  logic [NumTerms-1:0][GainW-1:0] mag_q;
  logic [NumTerms-1:0]            neg_q;
  logic                           neg_sel;

  logic [AccW-1:0]           acc_q, acc_d, addend;
  logic signed [WholeW-1:0]  whole;
  logic signed [DriveW-1:0]  drive_q, drive_d;
  logic signed [ErrW-1:0]    err_out_q;

  assign sts_o.cube_en = cfg_i.cube_error;

  assign err_lin_d = $signed(ErrLinW'(sample_i)) - $signed(ErrLinW'(cfg_i.setpoint));
  assign mag_lin   = err_lin_q[ErrLinW-1] ? MagLinW'(-err_lin_q) : MagLinW'(err_lin_q);

  // operand select for the shared 48x16 multiplier
  always_comb begin
    unique case (cmd_i.term)
      TermInt: begin
        gain_sel = cfg_i.gain_i;
        mag_sel  = mag_q[0];
        neg_sel  = neg_q[0];
      end
      TermDeriv: begin
        gain_sel = cfg_i.gain_d;
        mag_sel  = mag_q[1];
        neg_sel  = neg_q[1];
      end
      TermProp: begin
        gain_sel = cfg_i.gain_p;
        mag_sel  = mag_q[2];
        neg_sel  = neg_q[2];
      end
      default: begin
        gain_sel = '0;
        mag_sel  = '0;
        neg_sel  = 1'b0;
      end
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.mul_op)
      MulNone: begin
        mul_a = '0;
      end
      MulSquare: begin
        mul_a = GainW'(mag_lin);
        mul_b = DigitW'(mag_lin);
      end
      MulCube: begin
        mul_a = prod_q[GainW-1:0];
        mul_b = DigitW'(mag_lin);
      end
      MulTerm: begin
        mul_a = gain_sel;
        mul_b = DigitW'(mag_sel >> (DigitW * cmd_i.digit));
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // cube magnitude sits in the product register, sign from the linear error
  always_comb begin
    if (err_lin_q[ErrLinW-1]) begin
      cube_sat = (|prod_q[ProdW-1:ErrW-1]) ? ErrMin : -$signed(prod_q[ErrW-1:0]);
    end else begin
      cube_sat = (|prod_q[ProdW-1:ErrW-1]) ? ErrMax : $signed(prod_q[ErrW-1:0]);
    end
  end

  assign err_d = cfg_i.cube_error ? cube_sat : ErrW'(err_lin_q);

  // integral with deadband and 48-bit saturation
  assign err_abs  = err_q[ErrW-1] ? -err_q : err_q;
  assign int_base = clr_q ? '0 : int_q;
  assign int_sum  = (IntW+1)'(int_base) + (IntW+1)'(err_q);
  assign int_sat  = (int_sum[IntW] != int_sum[IntW-1]) ?
                    (int_sum[IntW] ? IntMin : IntMax) : int_sum[IntW-1:0];
  assign int_d    = (err_abs < ErrW'(cfg_i.deadband)) ? '0 : int_sat;
  assign deriv_d  = DerivW'(err_q) - DerivW'(prev_q);

  assign int_abs   = int_q[IntW-1] ? -int_q : int_q;
  assign deriv_abs = deriv_q[DerivW-1] ? -deriv_q : deriv_q;

  // signed accumulate of one shifted partial product
  assign addend = AccW'(prod_q) << (DigitW * cmd_i.digit);
  assign acc_d  = neg_sel ? acc_q - addend : acc_q + addend;

  // floor shift and clamp to the drive limit
  assign whole   = $signed(acc_q[AccW-1:FracBits]);
  assign drive_d = (whole > LimPos) ? DrivePos :
                   (whole < LimNeg) ? DriveNeg : DriveW'(whole);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_q  <= '0;
      prev_q <= '0;
    end else if (cmd_i.int_update) begin
      int_q  <= int_d;
      prev_q <= err_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      err_lin_q <= err_lin_d;
      clr_q     <= clear_i;
    end
    if (cmd_i.mul_op != MulNone) begin
      prod_q <= prod_d;
    end
    if (cmd_i.err_load) begin
      err_q <= err_d;
    end
    if (cmd_i.int_update) begin
      deriv_q <= deriv_d;
    end
    if (cmd_i.mag_load) begin
      mag_q[0] <= int_abs;
      neg_q[0] <= int_q[IntW-1];
      mag_q[1] <= GainW'(deriv_abs);
      neg_q[1] <= deriv_q[DerivW-1];
      mag_q[2] <= GainW'(err_abs);
      neg_q[2] <= err_q[ErrW-1];
    end
    if (cmd_i.load) begin
      acc_q <= '0;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_d;
    end
    if (cmd_i.out_load) begin
      drive_q   <= drive_d;
      err_out_q <= err_q;
    end
  end

  assign drive_o = drive_q;
  assign error_o = err_out_q;

endmodule

// ===== rtl/pid_with_integral_deadband_core.sv =====
// top level of the pid controller with integral deadband: config registers and stream ports
// per input beat: optional square and cube, then error, integral and magnitude steps, then
// nine multiply/accumulate passes (three gains by three 16-bit digits) through one shared
// 48x16 multiplier, each a multiply state and an accumulate state, then the result write
// one beat in flight: the next beat is taken after the result write, which waits on a full slot
// reset: integral and previous error cleared, registers at defaults (deadband 20), no sweep
module pid_with_integral_deadband_core import pidd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InDataW-1:0]   s_axis_tdata,   // [11:0] sample, rest zero
  input  logic                 s_axis_tuser,   // [0] clear_integral
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutDataW-1:0]  m_axis_tdata,   // [14:0] drive_mv, [46:15] error_out, [47] zero
  // register write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  cfg_t                     cfg_q, cfg_d;
  dp_cmd_t                  cmd;
  dp_sts_t                  sts;
  logic signed [DriveW-1:0] drive;
  logic signed [ErrW-1:0]   error;

  // register writes are always taken; unknown indexes are dropped
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgSetpoint: cfg_d.setpoint   = cfg_data_i[SetpointW-1:0];
        CfgGainP:    cfg_d.gain_p     = cfg_data_i[GainW-1:0];
        CfgGainI:    cfg_d.gain_i     = cfg_data_i[GainW-1:0];
        CfgGainD:    cfg_d.gain_d     = cfg_data_i[GainW-1:0];
        CfgDeadband: cfg_d.deadband   = cfg_data_i[DeadbandW-1:0];
        CfgCube:     cfg_d.cube_error = cfg_data_i[0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // sequencer: one beat in flight, result slot decouples the output side
  pidd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // arithmetic: error, optional cube, integral, derivative, gain products
  pidd_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .sample_i (s_axis_tdata[SampleBits-1:0]),
    .clear_i  (s_axis_tuser),
    .drive_o  (drive),
    .error_o  (error)
  );

  // result beat packed from the lowest bit up
  assign m_axis_tdata = {{(OutDataW-DriveW-ErrW){1'b0}}, error, drive};

endmodule

// ===== verif/pidd_drive_checker.sv =====
`timescale 1ns / 100ps
// checker for the pid core: predicts drive and error per sample beat and compares result beats
module pidd_drive_checker import pidd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [InDataW-1:0]   s_axis_tdata,
  input  logic                 s_axis_tuser,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [OutDataW-1:0]  m_axis_tdata,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  localparam longint ErrMax = (longint'(1) <<< (ErrW - 1)) - 1;
  localparam longint ErrMin = -ErrMax - 1;
  localparam longint IntMax = (longint'(1) <<< (IntW - 1)) - 1;
  localparam longint IntMin = -IntMax - 1;

  typedef struct {
    logic signed [DriveW-1:0] drive_mv;
    logic signed [ErrW-1:0]   error_out;
  } tick_result_t;

  cfg_t         model_cfg;
  longint       integ_sum;
  longint       last_err;
  tick_result_t expected_drive_q[$];
  int           mismatches = 0;
  int           in_flight  = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = in_flight;

  function automatic logic signed [127:0] gain_product(logic [GainW-1:0] gain, longint x);
    logic signed [127:0] g, v;
    g = {{(128 - GainW){1'b0}}, gain};
    v = x;
    return g * v;
  endfunction

  // one control tick: updates the integral and previous error, returns the result beat
  function automatic tick_result_t control_tick(logic [SampleBits-1:0] sample, logic clr);
    longint              err, mag, deriv;
    logic signed [127:0] acc;
    tick_result_t        r;
    err = longint'(sample) - longint'(model_cfg.setpoint);
    if (model_cfg.cube_error) err = err * err * err;
    if (err > ErrMax) err = ErrMax;
    if (err < ErrMin) err = ErrMin;
    if (clr) integ_sum = 0;
    mag = (err < 0) ? -err : err;
    if (mag < longint'(model_cfg.deadband)) begin
      integ_sum = 0;
    end else begin
      integ_sum = integ_sum + err;
      if (integ_sum > IntMax) integ_sum = IntMax;
      if (integ_sum < IntMin) integ_sum = IntMin;
    end
    deriv = err - last_err;
    acc = gain_product(model_cfg.gain_i, integ_sum) + gain_product(model_cfg.gain_d, deriv)
        + gain_product(model_cfg.gain_p, err);
    acc = acc >>> FracBits;
    if (acc > DriveLimit) r.drive_mv = DriveW'(DriveLimit);
    else if (acc < -DriveLimit) r.drive_mv = DriveW'(-DriveLimit);
    else r.drive_mv = acc[DriveW-1:0];
    r.error_out = err[ErrW-1:0];
    last_err = err;
    return r;
  endfunction

  task automatic flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tick_result_t want, got;
    if (!rst_ni) begin
      model_cfg = CfgReset;
      integ_sum = 0;
      last_err  = 0;
      expected_drive_q.delete();
      in_flight = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CfgSetpoint: model_cfg.setpoint   = cfg_data_i[SetpointW-1:0];
          CfgGainP:    model_cfg.gain_p     = cfg_data_i[GainW-1:0];
          CfgGainI:    model_cfg.gain_i     = cfg_data_i[GainW-1:0];
          CfgGainD:    model_cfg.gain_d     = cfg_data_i[GainW-1:0];
          CfgDeadband: model_cfg.deadband   = cfg_data_i[DeadbandW-1:0];
          CfgCube:     model_cfg.cube_error = cfg_data_i[0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.drive_mv  = m_axis_tdata[DriveW-1:0];
        got.error_out = m_axis_tdata[DriveW +: ErrW];
        if (expected_drive_q.size() == 0) begin
          flag_mismatch($sformatf("result beat with nothing expected (drive %0d, error %0d)",
                                  got.drive_mv, got.error_out));
        end else begin
          want = expected_drive_q.pop_front();
          if (got.drive_mv !== want.drive_mv)
            flag_mismatch($sformatf("drive_mv expected %0d, got %0d",
                                    want.drive_mv, got.drive_mv));
          if (got.error_out !== want.error_out)
            flag_mismatch($sformatf("error_out expected %0d, got %0d",
                                    want.error_out, got.error_out));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_drive_q.push_back(control_tick(s_axis_tdata[SampleBits-1:0], s_axis_tuser));
      in_flight = expected_drive_q.size();
    end
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// top of the pid core testbench: clock, reset, sample and register stimulus, verdict
module testbench;
  import pidd_pkg::*;

  // register indexes the core has no register behind, writes there must be dropped
  localparam logic [CfgIndexW-1:0] CfgUnusedLo = 3'd6;
  localparam logic [CfgIndexW-1:0] CfgUnusedHi = 3'd7;
  localparam int SampleMax  = (1 << SampleBits) - 1;
  localparam int TickTarget = 1300;
  localparam int StallLimit = 2000;  // cycles without any beat before giving up
  localparam int DrainWait  = 40;    // a bit above the worst case latency of a result, with cubing

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 s_valid   = 1'b0;
  logic                 s_ready;
  logic [InDataW-1:0]   s_data    = '0;
  logic                 s_user    = 1'b0;
  logic                 m_valid;
  logic                 m_ready   = 1'b0;
  logic [OutDataW-1:0]  m_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data  = '0;
  int                   fail_count;
  int                   pending;
  int                   idle_cycles = 0;
  bit                   quiet = 1'b0;  // phase with no gaps on either side

  always #10 clk = ~clk;

  pid_with_integral_deadband_core uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  pidd_drive_checker u_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // mostly no gap or a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 80);
  endfunction

  // zero, all ones, or a random value scaled down so all magnitudes show up
  function automatic logic [GainW-1:0] random_gain();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return raw[GainW-1:0] >> $urandom_range(0, GainW - 1);
    endcase
  endfunction

  // watchdog: ends the run when no channel has moved a beat for too long
  always @(posedge clk) begin
    if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: ready held for a random stretch, then dropped for a random stall
  initial begin : result_sink
    int hold, stall;
    forever begin
      hold = quiet ? 64 : $urandom_range(1, 40);
      @(posedge clk);
      m_ready <= 1'b1;
      repeat (hold) @(posedge clk);
      stall = quiet ? 0 : pick_gap();
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // one register write beat, with valid dropped again before the task returns
  task automatic write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_settings(logic [SetpointW-1:0] sp, logic [GainW-1:0] kp,
                               logic [GainW-1:0] ki, logic [GainW-1:0] kd,
                               logic [DeadbandW-1:0] db, logic cube);
    write_reg(CfgSetpoint, CfgDataW'(sp));
    write_reg(CfgGainP, kp);
    write_reg(CfgGainI, ki);
    write_reg(CfgGainD, kd);
    write_reg(CfgDeadband, CfgDataW'(db));
    write_reg(CfgCube, CfgDataW'(cube));
  endtask

  // one sample beat; valid stays high into the next beat when there is no gap
  task automatic send_tick(logic [SampleBits-1:0] sample, logic clr);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= InDataW'(sample);
    s_user  <= clr;
    do @(posedge clk); while (!s_ready);
  endtask

  // stop sending and wait for every expected result; pending is looked at away from the edge
  task automatic drain();
    s_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  initial begin : stimulus
    int                   ticks_sent;
    int                   burst, v, walk, reach;
    logic [SetpointW-1:0] sp;
    logic [DeadbandW-1:0] db;
    logic                 clr;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: all gains zero, deadband 20
    send_tick(SampleBits'(SampleMax), 1'b0);
    send_tick('0, 1'b0);
    drain();

    // setpoint mid scale, kp of 1.5 so odd errors show the floor on the shift
    load_settings(12'd2048, 48'h1_8000_0000, 48'h0_1000_0000, 48'h0_8000_0000, 12'd20, 1'b0);
    send_tick(12'd2047, 1'b0);                   // error -1, drive floors to -2
    send_tick(12'd2049, 1'b0);                   // error +1, drive floors to 2
    send_tick(12'd2048, 1'b0);                   // zero error
    send_tick(12'd2067, 1'b0);                   // just inside the deadband, integral cleared
    send_tick(12'd2068, 1'b0);                   // on the deadband edge, integral accumulates
    send_tick(SampleBits'(SampleMax), 1'b0);
    send_tick(SampleBits'(SampleMax), 1'b1);     // clear together with a large error
    send_tick('0, 1'b0);
    send_tick('0, 1'b1);
    drain();

    // upper data bits must be dropped, unused indexes ignored, deadband ends up zero
    write_reg(CfgSetpoint, 48'hFFFF_FFFF_F800);
    write_reg(CfgDeadband, 48'hABCD_EF12_3000);
    write_reg(CfgCube, 48'hFFFF_FFFF_FFFE);
    write_reg(CfgUnusedLo, '1);
    write_reg(CfgUnusedHi, '1);
    send_tick(12'd2048, 1'b0);                   // zero error still accumulates
    send_tick(12'd2050, 1'b0);
    drain();

    // cubed errors past the 32-bit range with every gain at full scale
    load_settings('0, '1, '1, '1, 12'd4095, 1'b1);
    send_tick(SampleBits'(SampleMax), 1'b0);
    send_tick(12'd1, 1'b0);
    drain();
    load_settings(12'd4095, '1, '1, '1, '0, 1'b1);
    send_tick('0, 1'b0);
    send_tick(12'd4094, 1'b0);
    send_tick('0, 1'b1);
    drain();
    ticks_sent = 18;

    // random phases: fresh settings, then a burst of control ticks
    while (ticks_sent < TickTarget) begin
      quiet = ($urandom_range(0, 5) == 0);
      case ($urandom_range(0, 5))
        0:       sp = '0;
        1:       sp = '1;
        default: sp = SetpointW'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0:       db = '0;
        1:       db = '1;
        2, 3:    db = DeadbandW'($urandom_range(1, 100));
        default: db = DeadbandW'($urandom);
      endcase
      load_settings(sp, random_gain(), random_gain(), random_gain(), db,
                    1'($urandom_range(0, 1)));
      burst = $urandom_range(40, 110);
      walk  = int'(sp);
      reach = int'(db) + 8;
      repeat (burst) begin
        case ($urandom_range(0, 9))
          0, 1, 2: v = $urandom_range(0, SampleMax);
          3, 4, 5: v = int'(sp) - reach + int'($urandom_range(0, 2 * reach));
          6, 7:    v = walk + int'($urandom_range(0, 128)) - 64;
          default: v = $urandom_range(0, 1) ? SampleMax : 0;
        endcase
        if (v < 0) v = 0;
        if (v > SampleMax) v = SampleMax;
        walk = v;
        clr = ($urandom_range(0, 15) == 0);
        send_tick(SampleBits'(v), clr);
        ticks_sent++;
      end
      drain();
    end

    // let any stray result show up before the verdict
    repeat (DrainWait) @(posedge clk);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
